### sv/clut_pkg.sv
// Shared types, widths and helpers for the interpolating curve lookup.
`timescale 1ns / 1ps

package clut_pkg;

	localparam int POINTS    = 16;
	localparam int FRAC_BITS = 8;

	localparam int X_W       = 16;
	localparam int IDX_W     = $clog2(POINTS);
	localparam int ARG_W     = X_W + FRAC_BITS;
	localparam int NUM_W     = X_W + ARG_W;
	localparam int ARG_IN_W  = 24;
	localparam int RES_W     = 24;
	localparam int MUL_CNT_W = $clog2(X_W);
	localparam int DIV_CNT_W = $clog2(ARG_W);

	localparam logic [IDX_W-1:0] LAST_PT = IDX_W'(POINTS - 1);
	localparam logic [IDX_W-1:0] LAST_IV = IDX_W'(POINTS - 2);

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_WR_X   = 2'd1,
		ACT_WR_Y   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_UNSORTED = 1'b1;

	typedef struct packed {
		logic [1:0]          action;
		logic [3:0]          point_index;
		logic [X_W-1:0]      point_value;
		logic [ARG_IN_W-1:0] argument;
	} clut_req_t;

	typedef struct packed {
		logic [RES_W-1:0] result_value;
		logic             status;
	} clut_rsp_t;

	typedef struct packed {
		logic             sel_x;
		logic             sel_y;
		logic [IDX_W-1:0] idx;
		logic [X_W-1:0]   value;
	} clut_wr_t;

	function automatic logic [ARG_W-1:0] shl_frac(input logic [X_W-1:0] v);
		return ARG_W'(v) << FRAC_BITS;
	endfunction

endpackage

### sv/interpolating_curve_lookup.sv
// Top level: piecewise-linear curve lookup with cached interval search.
//
//  channel   ports                  handshake
//  request   start, busy, req       taken when start is high and busy is low
//  result    done, rsp              one-cycle strobe, cannot be held off
//
// A write or an unused action answers in the cycle after the request.
// A lookup first checks the x axis order (an unsorted axis answers right
// after the first bad pair), then reads the two x points of each interval
// visited by the x search; a result off either end of the curve answers there.
// A hit adds two y reads, then the serial multiply and the serial divide.
// Reset clears the curve and the cached interval at once; no sweep follows.
`timescale 1ns / 1ps

module interpolating_curve_lookup import clut_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  clut_req_t req,
	output logic      done,
	output clut_rsp_t rsp
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_XA    = 8'b0000_0100,
		S_XB    = 8'b0000_1000,
		S_YA    = 8'b0001_0000,
		S_YB    = 8'b0010_0000,
		S_MUL   = 8'b0100_0000,
		S_DIV   = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic             done_q;
	clut_rsp_t        rsp_q;
	logic [IDX_W-1:0] cache_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] iv_q;
	logic [ARG_W-1:0] arg_q;
	logic [X_W-1:0]   prev_q;
	logic [X_W-1:0]   xa_q;
	logic [X_W-1:0]   ya_q;
	logic [X_W-1:0]   dx_q;
	logic             neg_q;

	logic             accept;
	logic             idx_ok;
	clut_wr_t         wr;
	logic [IDX_W-1:0] x_addr;
	logic [IDX_W-1:0] y_addr;
	logic [X_W-1:0]   x_rd;
	logic [X_W-1:0]   y_rd;
	logic             above;
	logic             below;
	logic [ARG_W-1:0] d_val;
	logic [X_W-1:0]   dy;
	logic             mul_start;
	logic             mul_done;
	logic [NUM_W-1:0] product;
	logic             div_done;
	logic [ARG_W-1:0] quo;
	logic             rem_nz;
	logic [ARG_W-1:0] base;
	logic [ARG_W-1:0] fin;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign idx_ok = (32'(req.point_index) < 32'(POINTS));

	assign wr.sel_x = accept && (req.action == ACT_WR_X) && idx_ok;
	assign wr.sel_y = accept && (req.action == ACT_WR_Y) && idx_ok;
	assign wr.idx   = IDX_W'(req.point_index);
	assign wr.value = req.point_value;

	always_comb begin
		x_addr = iv_q;
		y_addr = iv_q;
		unique case (state_q)
			S_CHECK: x_addr = i_q;
			S_XB: begin
				x_addr = iv_q + IDX_W'(1);
				y_addr = above ? LAST_PT : '0;
			end
			S_YB:    y_addr = iv_q + IDX_W'(1);
			default: ;
		endcase
	end

	clut_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.x_addr (x_addr),
		.y_addr (y_addr),
		.x_data (x_rd),
		.y_data (y_rd)
	);

	assign above     = arg_q > shl_frac(x_rd);
	assign below     = arg_q < shl_frac(xa_q);
	assign d_val     = arg_q - shl_frac(xa_q);
	assign dy        = (y_rd < ya_q) ? (ya_q - y_rd) : (y_rd - ya_q);
	assign mul_start = (state_q == S_YB);

	clut_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (d_val),
		.mplier  (dy),
		.done    (mul_done),
		.product (product)
	);

	clut_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_done),
		.num    (product),
		.den    (dx_q),
		.done   (div_done),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	assign base = shl_frac(ya_q);
	assign fin  = neg_q ? (base - quo - ARG_W'(rem_nz)) : (base + quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cache_q <= '0;
			i_q     <= '0;
			iv_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.action == ACT_LOOKUP) begin
							i_q     <= '0;
							state_q <= S_CHECK;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_CHECK: begin
					if ((i_q != '0) && (prev_q >= x_rd)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (i_q == LAST_PT) begin
						iv_q    <= (cache_q > LAST_IV) ? LAST_IV : cache_q;
						state_q <= S_XA;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				S_XA: state_q <= S_XB;
				S_XB: begin
					priority if (above) begin
						if (iv_q == LAST_IV) begin
							cache_q <= LAST_PT;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							iv_q    <= iv_q + IDX_W'(1);
							state_q <= S_XA;
						end
					end else if (below) begin
						if (iv_q == '0) begin
							cache_q <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							iv_q    <= iv_q - IDX_W'(1);
							state_q <= S_XA;
						end
					end else begin
						cache_q <= iv_q;
						state_q <= S_YA;
					end
				end
				S_YA: state_q <= S_YB;
				S_YB: state_q <= S_MUL;
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				arg_q              <= req.argument[ARG_W-1:0];
				rsp_q.result_value <= '0;
				rsp_q.status       <= ST_OK;
			end
			S_CHECK: begin
				prev_q             <= x_rd;
				rsp_q.result_value <= '0;
				rsp_q.status       <= ST_UNSORTED;
			end
			S_XA: xa_q <= x_rd;
			S_XB: begin
				dx_q               <= x_rd - xa_q;
				rsp_q.result_value <= RES_W'(shl_frac(y_rd));
				rsp_q.status       <= ST_OK;
			end
			S_YA: ya_q <= y_rd;
			S_YB: neg_q <= (y_rd < ya_q);
			S_MUL: ;
			S_DIV: begin
				rsp_q.result_value <= RES_W'(fin);
				rsp_q.status       <= ST_OK;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result strobe without a request in progress");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_UNSORTED) |-> (rsp.result_value == '0))
		else $error("axis error with nonzero result");

	a_mul_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL))
		else $error("multiplier finished outside multiply phase");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide phase");

	a_iv_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XA) || (state_q == S_XB) |-> (iv_q <= LAST_IV))
		else $error("search interval out of range");

endmodule

### sv/clut_store.sv
// Curve point store: x and y axis registers, one write and one read per axis.
`timescale 1ns / 1ps

module clut_store import clut_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  clut_wr_t         wr,
	input  logic [IDX_W-1:0] x_addr,
	input  logic [IDX_W-1:0] y_addr,
	output logic [X_W-1:0]   x_data,
	output logic [X_W-1:0]   y_data
);

	logic [X_W-1:0] x_q [POINTS];
	logic [X_W-1:0] y_q [POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POINTS; i++) begin
				x_q[i] <= '0;
				y_q[i] <= '0;
			end
		end else begin
			if (wr.sel_x) begin
				x_q[wr.idx] <= wr.value;
			end
			if (wr.sel_y) begin
				y_q[wr.idx] <= wr.value;
			end
		end
	end

	assign x_data = x_q[x_addr];
	assign y_data = y_q[y_addr];

endmodule

### sv/clut_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module clut_mul import clut_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ARG_W-1:0] mcand,
	input  logic [X_W-1:0]   mplier,
	output logic             done,
	output logic [NUM_W-1:0] product
);

	logic                 run_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     acc_q;
	logic [NUM_W-1:0]     mc_q;
	logic [X_W-1:0]       mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(X_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= NUM_W'(mcand);
			mp_q  <= mplier;
		end else if (run_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### sv/clut_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module clut_div import clut_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [X_W-1:0]   den,
	output logic             done,
	output logic [ARG_W-1:0] quo,
	output logic             rem_nz
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [X_W-1:0]       rem_q;
	logic [ARG_W-1:0]     sh_q;
	logic [X_W:0]         trial;
	logic [X_W:0]         diff;
	logic                 ge;

	assign trial = {rem_q, sh_q[ARG_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(ARG_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:ARG_W];
			sh_q  <= num[ARG_W-1:0];
		end else if (run_q) begin
			rem_q <= ge ? diff[X_W-1:0] : trial[X_W-1:0];
			sh_q  <= {sh_q[ARG_W-2:0], ge};
		end
	end

	assign done   = done_q;
	assign quo    = sh_q;
	assign rem_nz = (rem_q != '0);

endmodule
